// File: rtl/wtpq_pkg.sv
// Shared types and constants for the wake-up time priority queue.
// No dependencies; used by wtpq_cell and wakeup_time_priority_queue.
package wtpq_pkg;

    localparam int TIME_BITS = 32;
    localparam int ID_BITS   = 8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic                 opcode;
        logic [ID_BITS-1:0]   task_id;
        logic [TIME_BITS-1:0] time_value;
    } t_in;

    typedef struct packed {
        logic [1:0]           status;
        logic [ID_BITS-1:0]   popped_id;
        logic [TIME_BITS-1:0] popped_time;
        logic                 queue_empty;
    } t_out;

    // One stored entry.
    typedef struct packed {
        logic [TIME_BITS-1:0] wake_time;
        logic [ID_BITS-1:0]   id;
    } t_entry;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [TIME_BITS-1:0] wake_time;
        logic [ID_BITS-1:0]   id;
    } t_cmd;

endpackage

// File: rtl/wtpq_cell.sv
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast push time and shifts with its neighbors. Depends on wtpq_pkg.
module wtpq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wtpq_pkg::t_cmd  i_cmd,
    input  logic            i_left_valid,
    input  wtpq_pkg::t_entry i_left_entry,
    input  logic            i_left_ge,
    input  logic            i_right_valid,
    input  wtpq_pkg::t_entry i_right_entry,
    output logic            o_valid,
    output wtpq_pkg::t_entry o_entry,
    output logic            o_ge
);

    logic             r_valid;
    logic             n_valid;
    wtpq_pkg::t_entry r_entry;
    wtpq_pkg::t_entry n_entry;
    logic             ge;

    // Empty slots count as later than anything, so the insert point is the
    // first cell where this goes high.
    assign ge = !r_valid || (r_entry.wake_time >= i_cmd.wake_time);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_cmd.push) begin
            if (i_left_ge) begin
                n_valid = i_left_valid;
                n_entry = i_left_entry;
            end else if (ge) begin
                n_valid = 1'b1;
                n_entry.wake_time = i_cmd.wake_time;
                n_entry.id        = i_cmd.id;
            end
        end else if (i_cmd.pop) begin
            n_valid = i_right_valid;
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_ge    = ge;

endmodule

// File: rtl/wakeup_time_priority_queue.sv
// Sorted timer queue of DEPTH entries, built as a chain of wtpq_cell slots.
// Depends on wtpq_pkg and wtpq_cell.
//
// One command beat (push or pop) is taken per clock: busy is always low.
// Its result appears on o_result with o_done high for exactly one cycle, the
// cycle after the command was taken; the receiver cannot stall it. Every
// slot compares the push time against its own entry in parallel and shifts
// by one place with its neighbor in the same cycle, so latency does not
// depend on the fill level. Pushes into a full queue are dropped (status
// full); a pop returns the head only when its wake time is at most the
// given current time.
module wakeup_time_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  wtpq_pkg::t_in  i_in,
    output logic           o_done,
    output wtpq_pkg::t_out o_result
);

    logic             valid [DEPTH];
    wtpq_pkg::t_entry entry [DEPTH];
    logic             ge    [DEPTH];
    wtpq_pkg::t_cmd   cmd;
    logic             full;
    logic             due;
    logic             take;

    wtpq_pkg::t_out r_out;
    wtpq_pkg::t_out n_out;
    logic           r_done;

    assign busy = 1'b0;
    assign take = start && !busy;
    assign full = valid[DEPTH-1];
    assign due  = valid[0] && (entry[0].wake_time <= i_in.time_value);

    always_comb begin
        cmd.push      = take && (i_in.opcode == wtpq_pkg::OP_PUSH) && !full;
        cmd.pop       = take && (i_in.opcode == wtpq_pkg::OP_POP) && due;
        cmd.wake_time = i_in.time_value;
        cmd.id        = i_in.task_id;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic             left_valid;
        wtpq_pkg::t_entry left_entry;
        logic             left_ge;
        logic             right_valid;
        wtpq_pkg::t_entry right_entry;

        if (g == 0) begin : g_head
            assign left_valid = 1'b0;
            assign left_entry = '0;
            assign left_ge    = 1'b0;
        end else begin : g_mid
            assign left_valid = valid[g-1];
            assign left_entry = entry[g-1];
            assign left_ge    = ge[g-1];
        end

        if (g == DEPTH-1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_entry = '0;
        end else begin : g_body
            assign right_valid = valid[g+1];
            assign right_entry = entry[g+1];
        end

        wtpq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_left_valid  (left_valid),
            .i_left_entry  (left_entry),
            .i_left_ge     (left_ge),
            .i_right_valid (right_valid),
            .i_right_entry (right_entry),
            .o_valid       (valid[g]),
            .o_entry       (entry[g]),
            .o_ge          (ge[g])
        );
    end

    always_comb begin
        n_out             = '0;
        n_out.queue_empty = !valid[0];
        if (i_in.opcode == wtpq_pkg::OP_PUSH) begin
            if (full) begin
                n_out.status = wtpq_pkg::ST_FULL;
            end else begin
                n_out.status      = wtpq_pkg::ST_PUSHED;
                n_out.queue_empty = 1'b0;
            end
        end else begin
            if (due) begin
                n_out.status      = wtpq_pkg::ST_POPPED;
                n_out.popped_id   = entry[0].id;
                n_out.popped_time = entry[0].wake_time;
                n_out.queue_empty = !valid[1];
            end else begin
                n_out.status = wtpq_pkg::ST_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

// File: tb/testbench.sv
// Self-checking bench for wakeup_time_priority_queue: directed table, then random push/pop beats.
// A local model of the sorted timer queue predicts untyped results; typed table rows give their own.
// Depends on wtpq_pkg and the RTL of the queue.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 16;
    localparam int RANDOM_BEATS = 1600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 27;
    localparam logic [wtpq_pkg::TIME_BITS-1:0] T_MAX = '1;

    typedef struct packed {
        wtpq_pkg::t_in  cmd;
        logic           typed;
        wtpq_pkg::t_out want;
    } t_dir_row;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    logic           busy;
    wtpq_pkg::t_in  i_in    = '0;
    logic           o_done;
    wtpq_pkg::t_out o_result;

    wakeup_time_priority_queue #(.DEPTH(SLOTS)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model of the timer queue: sorted by wake time, earliest at slot 0.
    wtpq_pkg::t_entry timers [SLOTS];
    int unsigned      timer_count = 0;
    wtpq_pkg::t_out   awaited_results [$];
    int unsigned      errors = 0;
    int unsigned      cycles = 0;
    bit               idle_enable = 1'b1;
    int unsigned      push_pct = 60;
    logic [wtpq_pkg::TIME_BITS-1:0] time_base = '0;

    t_dir_row directed_tab [N_DIRECTED] = '{
        // empty queue: nothing to pop
        '{'{wtpq_pkg::OP_POP, 8'd0, 32'd0}, 1'b1, '{wtpq_pkg::ST_NONE, 8'd0, 32'd0, 1'b1}},
        '{'{wtpq_pkg::OP_PUSH, 8'd255, T_MAX}, 1'b1,
          '{wtpq_pkg::ST_PUSHED, 8'd0, 32'd0, 1'b0}},
        '{'{wtpq_pkg::OP_PUSH, 8'h5a, 32'd0}, 1'b1,
          '{wtpq_pkg::ST_PUSHED, 8'd0, 32'd0, 1'b0}},
        '{'{wtpq_pkg::OP_PUSH, 8'd1, 32'd100}, 1'b1,
          '{wtpq_pkg::ST_PUSHED, 8'd0, 32'd0, 1'b0}},
        '{'{wtpq_pkg::OP_PUSH, 8'd2, 32'd100}, 1'b1,
          '{wtpq_pkg::ST_PUSHED, 8'd0, 32'd0, 1'b0}},
        '{'{wtpq_pkg::OP_POP, 8'd0, 32'd0}, 1'b1,
          '{wtpq_pkg::ST_POPPED, 8'h5a, 32'd0, 1'b0}},
        // head at 100 not due yet
        '{'{wtpq_pkg::OP_POP, 8'd0, 32'd50}, 1'b1, '{wtpq_pkg::ST_NONE, 8'd0, 32'd0, 1'b0}},
        // newest of the equal times comes out first
        '{'{wtpq_pkg::OP_POP, 8'd0, 32'd100}, 1'b1,
          '{wtpq_pkg::ST_POPPED, 8'd2, 32'd100, 1'b0}},
        '{'{wtpq_pkg::OP_POP, 8'd0, T_MAX}, 1'b1,
          '{wtpq_pkg::ST_POPPED, 8'd1, 32'd100, 1'b0}},
        '{'{wtpq_pkg::OP_POP, 8'd0, T_MAX}, 1'b1,
          '{wtpq_pkg::ST_POPPED, 8'd255, T_MAX, 1'b1}},
        // fill up to the last slot
        '{'{wtpq_pkg::OP_PUSH, 8'd10, 32'h8000_0000}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd11, 32'd7}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd12, 32'd7}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd0, T_MAX}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd255, 32'd0}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'h55, 32'h5555_5555}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'haa, 32'haaaa_aaaa}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd17, 32'd7}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd18, 32'hffff_fffe}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd19, 32'd1}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd20, 32'h0001_0000}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd21, 32'h7fff_ffff}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd22, 32'd8}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd23, 32'd6}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd24, T_MAX}, 1'b0, '0},
        '{'{wtpq_pkg::OP_PUSH, 8'd25, 32'd1000}, 1'b0, '0},
        // full: dropped
        '{'{wtpq_pkg::OP_PUSH, 8'd99, 32'd3}, 1'b1, '{wtpq_pkg::ST_FULL, 8'd0, 32'd0, 1'b0}}
    };

    function automatic wtpq_pkg::t_out timer_step(input wtpq_pkg::t_in c);
        wtpq_pkg::t_out r;
        int             pos;
        int             k;
        r = '0;
        r.status = wtpq_pkg::ST_NONE;
        if (c.opcode == wtpq_pkg::OP_PUSH) begin
            if (timer_count >= SLOTS) begin
                r.status = wtpq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < timer_count && timers[pos].wake_time < c.time_value)
                    pos++;
                for (k = timer_count; k > pos; k--)
                    timers[k] = timers[k-1];
                timers[pos].wake_time = c.time_value;
                timers[pos].id        = c.task_id;
                timer_count++;
                r.status = wtpq_pkg::ST_PUSHED;
            end
        end else if (timer_count != 0 && timers[0].wake_time <= c.time_value) begin
            r.status      = wtpq_pkg::ST_POPPED;
            r.popped_id   = timers[0].id;
            r.popped_time = timers[0].wake_time;
            for (k = 1; k < timer_count; k++)
                timers[k-1] = timers[k];
            timer_count--;
        end
        r.queue_empty = (timer_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // One command beat; the expectation is queued at the accepting edge.
    task automatic issue(input wtpq_pkg::t_in cmd, input logic typed,
                         input wtpq_pkg::t_out want);
        wtpq_pkg::t_out predicted;
        while (idle_enable && $urandom_range(0, 99) < 33) begin
            start <= 1'b0;
            i_in  <= wtpq_pkg::t_in'({$urandom, $urandom});
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= cmd;
        do @(posedge i_clk); while (busy);
        predicted = timer_step(cmd);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    function automatic wtpq_pkg::t_in random_cmd();
        wtpq_pkg::t_in c;
        int unsigned   roll;
        c.task_id = 8'($urandom_range(0, 255));
        c.opcode  = ($urandom_range(0, 99) < push_pct) ? wtpq_pkg::OP_PUSH : wtpq_pkg::OP_POP;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            c.time_value = $urandom;
        else if (roll == 1)
            c.time_value = '0;
        else if (roll == 2)
            c.time_value = T_MAX;
        else if (roll < 6)
            c.time_value = time_base + $urandom_range(0, 3);
        else if (c.opcode == wtpq_pkg::OP_PUSH)
            c.time_value = time_base + $urandom_range(0, 63);
        else
            c.time_value = time_base + $urandom_range(0, 96);
        return c;
    endfunction

    always @(posedge i_clk) begin
        wtpq_pkg::t_out want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(o_result), '0);
            end else begin
                want = awaited_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", 64'(o_result.status), 64'(want.status));
                if (o_result.popped_id !== want.popped_id)
                    report_mismatch("popped_id", 64'(o_result.popped_id),
                                    64'(want.popped_id));
                if (o_result.popped_time !== want.popped_time)
                    report_mismatch("popped_time", 64'(o_result.popped_time),
                                    64'(want.popped_time));
                if (o_result.queue_empty !== want.queue_empty)
                    report_mismatch("queue_empty", 64'(o_result.queue_empty),
                                    64'(want.queue_empty));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            issue(directed_tab[i].cmd, directed_tab[i].typed, directed_tab[i].want);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // new fill trend and time window every hundred beats
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 75;
                    1: push_pct = 30;
                    default: push_pct = 55;
                endcase
                time_base = ($urandom_range(0, 3) == 0) ? T_MAX - 40 : $urandom;
            end
            idle_enable = !(n >= 300 && n < 550);
            if (n == 800) begin
                start <= 1'b0;
                while (awaited_results.size() != 0) @(posedge i_clk);
            end
            issue(random_cmd(), 1'b0, '0);
        end

        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
